/* src/grapheme_cluster_boundary_macros.svh */
// assertion macros for the grapheme cluster boundary block
`ifndef GRAPHEME_CLUSTER_BOUNDARY_MACROS_SVH
`define GRAPHEME_CLUSTER_BOUNDARY_MACROS_SVH

// same-cycle implication, checked outside reset
`define GCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/gcb_pkg.sv */
// types, codes and helpers shared by the grapheme cluster boundary block
package gcb_pkg;

   localparam int CpWidth    = 21;
   localparam int ClassWidth = 4;
   localparam int IncbWidth  = 2;
   localparam int OffWidth   = 14;

   localparam logic [ClassWidth-1:0] CLASS_OTHER   = 4'd0;
   localparam logic [ClassWidth-1:0] CLASS_CR      = 4'd1;
   localparam logic [ClassWidth-1:0] CLASS_LF      = 4'd2;
   localparam logic [ClassWidth-1:0] CLASS_CONTROL = 4'd3;
   localparam logic [ClassWidth-1:0] CLASS_EXTEND  = 4'd4;
   localparam logic [ClassWidth-1:0] CLASS_ZWJ     = 4'd5;
   localparam logic [ClassWidth-1:0] CLASS_RI      = 4'd6;
   localparam logic [ClassWidth-1:0] CLASS_PREPEND = 4'd7;
   localparam logic [ClassWidth-1:0] CLASS_SPACING = 4'd8;
   localparam logic [ClassWidth-1:0] CLASS_L       = 4'd9;
   localparam logic [ClassWidth-1:0] CLASS_V       = 4'd10;
   localparam logic [ClassWidth-1:0] CLASS_T       = 4'd11;
   localparam logic [ClassWidth-1:0] CLASS_LV      = 4'd12;
   localparam logic [ClassWidth-1:0] CLASS_LVT     = 4'd13;

   localparam logic [IncbWidth-1:0] INCB_NONE      = 2'd0;
   localparam logic [IncbWidth-1:0] INCB_CONSONANT = 2'd1;
   localparam logic [IncbWidth-1:0] INCB_LINKER    = 2'd2;
   localparam logic [IncbWidth-1:0] INCB_EXTEND    = 2'd3;

   localparam logic [1:0] PROG_IDLE      = 2'd0;
   localparam logic [1:0] PROG_CONSONANT = 2'd1;
   localparam logic [1:0] PROG_LINKED    = 2'd2;

   localparam logic [CpWidth-1:0] HANGUL_FIRST = 21'h00AC00;
   localparam logic [CpWidth-1:0] HANGUL_LAST  = 21'h00D7A3;

   localparam logic REG_CONJUNCT_ENABLE = 1'b0;

   typedef struct packed {
      logic                  text_start;
      logic [ClassWidth-1:0] cls;
      logic                  pic;
      logic [IncbWidth-1:0]  incb;
   } item_type;

   function automatic logic is_control(input logic [ClassWidth-1:0] c);
      return c == CLASS_CR || c == CLASS_LF || c == CLASS_CONTROL;
   endfunction

   // offset mod 28 == 0: low two bits clear and offset/4 mod 7 == 0 (octal digit sum)
   function automatic logic hangul_is_lv(input logic [OffWidth-1:0] offset);
      logic [11:0] q;
      logic [4:0]  s1;
      logic [3:0]  s2;
      q  = offset[13:2];
      s1 = 5'(q[2:0]) + 5'(q[5:3]) + 5'(q[8:6]) + 5'(q[11:9]);
      s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
      return (offset[1:0] == 2'b00) && (s2 == 4'd0 || s2 == 4'd7);
   endfunction

endpackage

/* src/gcb_req_if.sv */
// input channel: one code point with its table properties per transfer
interface gcb_req_if;
   logic                             valid;
   logic                             ready;
   logic                             text_start;
   logic [gcb_pkg::CpWidth-1:0]      code_point;
   logic [gcb_pkg::ClassWidth-1:0]   table_class;
   logic                             ext_pictographic;
   logic [gcb_pkg::IncbWidth-1:0]    conjunct_class;

   modport source (
      output valid, text_start, code_point, table_class, ext_pictographic, conjunct_class,
      input  ready
   );
   modport sink (
      input  valid, text_start, code_point, table_class, ext_pictographic, conjunct_class,
      output ready
   );
endinterface

/* src/gcb_rsp_if.sv */
// result channel: one boundary flag per transfer
interface gcb_rsp_if;
   logic valid;
   logic ready;
   logic boundary_before;

   modport source (
      output valid, boundary_before,
      input  ready
   );
   modport sink (
      input  valid, boundary_before,
      output ready
   );
endinterface

/* src/gcb_csr.sv */
// configuration register file with apb-style access
module gcb_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        conjunct_enable
);
   logic conjunct_enable_ff;
   logic conjunct_enable_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      conjunct_enable_in = conjunct_enable_ff;
      if (wr_en && paddr == gcb_pkg::REG_CONJUNCT_ENABLE) begin
         conjunct_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conjunct_enable_ff <= 1'b1;
      end else begin
         conjunct_enable_ff <= conjunct_enable_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr == gcb_pkg::REG_CONJUNCT_ENABLE) begin
         prdata = {31'd0, conjunct_enable_ff};
      end
   end

   assign conjunct_enable = conjunct_enable_ff;
endmodule

/* src/gcb_classify.sv */
// hangul syllable override of the table properties
module gcb_classify (
   input  logic                           text_start,
   input  logic [gcb_pkg::CpWidth-1:0]    code_point,
   input  logic [gcb_pkg::ClassWidth-1:0] table_class,
   input  logic                           ext_pictographic,
   input  logic [gcb_pkg::IncbWidth-1:0]  conjunct_class,
   output gcb_pkg::item_type              item
);
   logic                             in_hangul;
   logic [gcb_pkg::OffWidth-1:0]     offset;

   assign in_hangul = code_point >= gcb_pkg::HANGUL_FIRST &&
                      code_point <= gcb_pkg::HANGUL_LAST;
   assign offset    = gcb_pkg::OffWidth'(code_point - gcb_pkg::HANGUL_FIRST);

   always_comb begin
      item.text_start = text_start;
      item.cls        = table_class;
      item.pic        = ext_pictographic;
      item.incb       = conjunct_class;
      if (in_hangul) begin
         item.cls  = gcb_pkg::hangul_is_lv(offset) ? gcb_pkg::CLASS_LV : gcb_pkg::CLASS_LVT;
         item.pic  = 1'b0;
         item.incb = gcb_pkg::INCB_NONE;
      end
   end
endmodule

/* src/gcb_rules.sv */
// boundary rules and the open-cluster context registers
module gcb_rules (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              conjunct_enable,
   input  gcb_pkg::item_type item,
   output logic              boundary
);
   logic [gcb_pkg::ClassWidth-1:0] last_class_ff, last_class_in;
   logic                           in_pic_ff, in_pic_in;
   logic                           pic_joiner_ff, pic_joiner_in;
   logic [1:0]                     progress_ff, progress_in;
   logic                           ri_odd_ff, ri_odd_in;
   logic                           joins;
   logic                           hangul_join;
   logic                           extend_join;
   logic                           conjunct_join;
   logic                           emoji_join;
   logic                           ri_join;
   logic [gcb_pkg::ClassWidth-1:0] prev;
   logic [gcb_pkg::ClassWidth-1:0] cur;

   assign prev = last_class_ff;
   assign cur  = item.cls;

   always_comb begin
      hangul_join =
         (prev == gcb_pkg::CLASS_L && (cur == gcb_pkg::CLASS_L || cur == gcb_pkg::CLASS_V ||
                                       cur == gcb_pkg::CLASS_LV || cur == gcb_pkg::CLASS_LVT)) ||
         ((prev == gcb_pkg::CLASS_LV || prev == gcb_pkg::CLASS_V) &&
          (cur == gcb_pkg::CLASS_V || cur == gcb_pkg::CLASS_T)) ||
         ((prev == gcb_pkg::CLASS_LVT || prev == gcb_pkg::CLASS_T) && cur == gcb_pkg::CLASS_T);
      extend_join = cur == gcb_pkg::CLASS_EXTEND || cur == gcb_pkg::CLASS_ZWJ ||
                    cur == gcb_pkg::CLASS_SPACING || prev == gcb_pkg::CLASS_PREPEND;
      conjunct_join = item.incb == gcb_pkg::INCB_CONSONANT &&
                      progress_ff == gcb_pkg::PROG_LINKED && conjunct_enable;
      emoji_join = item.pic && prev == gcb_pkg::CLASS_ZWJ && pic_joiner_ff;
      ri_join    = prev == gcb_pkg::CLASS_RI && cur == gcb_pkg::CLASS_RI && ri_odd_ff;

      if (prev == gcb_pkg::CLASS_CR && cur == gcb_pkg::CLASS_LF) begin
         joins = 1'b1;
      end else if (gcb_pkg::is_control(prev) || gcb_pkg::is_control(cur)) begin
         joins = 1'b0;
      end else begin
         joins = hangul_join || extend_join || conjunct_join || emoji_join || ri_join;
      end
   end

   assign boundary = item.text_start || !joins;

   always_comb begin
      last_class_in = last_class_ff;
      in_pic_in     = in_pic_ff;
      pic_joiner_in = pic_joiner_ff;
      progress_in   = progress_ff;
      ri_odd_in     = ri_odd_ff;
      if (advance) begin
         last_class_in = cur;
         if (boundary) begin
            in_pic_in     = item.pic;
            pic_joiner_in = 1'b0;
            progress_in   = (item.incb == gcb_pkg::INCB_CONSONANT) ?
                            gcb_pkg::PROG_CONSONANT : gcb_pkg::PROG_IDLE;
            ri_odd_in     = cur == gcb_pkg::CLASS_RI;
         end else begin
            pic_joiner_in = cur == gcb_pkg::CLASS_ZWJ && in_pic_ff;
            if (item.pic) begin
               in_pic_in = 1'b1;
            end else if (cur != gcb_pkg::CLASS_EXTEND) begin
               in_pic_in = 1'b0;
            end
            case (item.incb)
               gcb_pkg::INCB_CONSONANT: progress_in = gcb_pkg::PROG_CONSONANT;
               gcb_pkg::INCB_LINKER: begin
                  if (progress_ff != gcb_pkg::PROG_IDLE) begin
                     progress_in = gcb_pkg::PROG_LINKED;
                  end
               end
               gcb_pkg::INCB_NONE: progress_in = gcb_pkg::PROG_IDLE;
               default: progress_in = progress_ff;
            endcase
            ri_odd_in = (cur == gcb_pkg::CLASS_RI) ? !ri_odd_ff : 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_class_ff <= gcb_pkg::CLASS_OTHER;
         in_pic_ff     <= 1'b0;
         pic_joiner_ff <= 1'b0;
         progress_ff   <= gcb_pkg::PROG_IDLE;
         ri_odd_ff     <= 1'b0;
      end else begin
         last_class_ff <= last_class_in;
         in_pic_ff     <= in_pic_in;
         pic_joiner_ff <= pic_joiner_in;
         progress_ff   <= progress_in;
         ri_odd_ff     <= ri_odd_in;
      end
   end
endmodule

/* src/grapheme_cluster_boundary.sv */
// Extended grapheme cluster boundary detector. Each transfer on req_chan carries one
// code point with its break class, pictographic flag and Indic conjunct class; each
// transfer on rsp_chan returns one flag saying whether a cluster starts at that code
// point, in input order. One code point is taken every clock cycle while the result
// side keeps up; a result passes through the input register, then the result register,
// where it waits until it is taken. A result that waits holds the input register, and
// with both registers full and the result not taken the input side stalls. The rate is
// set by the context registers and their update loop.
// Register 0 at byte address 0 (bit 0, reset 1) enables the Indic conjunct rule.
// No clearing pass follows reset.
`include "grapheme_cluster_boundary_macros.svh"
module grapheme_cluster_boundary (
   input  logic        clock,
   input  logic        reset,
   gcb_req_if.sink     req_chan,
   gcb_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic                           in_valid_ff, in_valid_in;
   logic                           in_start_ff;
   logic [gcb_pkg::CpWidth-1:0]    in_code_point_ff;
   logic [gcb_pkg::ClassWidth-1:0] in_class_ff;
   logic                           in_pic_ff;
   logic [gcb_pkg::IncbWidth-1:0]  in_incb_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_boundary_ff, rsp_boundary_in;
   logic                           advance;
   logic                           req_take;
   logic                           conjunct_enable;
   logic                           boundary;
   gcb_pkg::item_type              item;

   gcb_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .conjunct_enable (conjunct_enable)
   );

   gcb_classify u_classify (
      .text_start       (in_start_ff),
      .code_point       (in_code_point_ff),
      .table_class      (in_class_ff),
      .ext_pictographic (in_pic_ff),
      .conjunct_class   (in_incb_ff),
      .item             (item)
   );

   gcb_rules u_rules (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .conjunct_enable (conjunct_enable),
      .item            (item),
      .boundary        (boundary)
   );

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      rsp_valid_in    = rsp_valid_ff;
      rsp_boundary_in = rsp_boundary_ff;
      if (advance) begin
         rsp_valid_in    = 1'b1;
         rsp_boundary_in = boundary;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_boundary_ff <= rsp_boundary_in;
      if (req_take) begin
         in_start_ff      <= req_chan.text_start;
         in_code_point_ff <= req_chan.code_point;
         in_class_ff      <= req_chan.table_class;
         in_pic_ff        <= req_chan.ext_pictographic;
         in_incb_ff       <= req_chan.conjunct_class;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.boundary_before = rsp_boundary_ff;

   `GCB_ASSERT_NEXT(a_start_breaks, clock, reset, advance && in_start_ff,
                    rsp_valid_ff && rsp_boundary_ff, "text start without boundary")
   `GCB_ASSERT_NEXT(a_advance_fills, clock, reset, advance, rsp_valid_ff,
                    "result lost after advance")
   `GCB_ASSERT_NOW(a_stall_cause, clock, reset, !req_chan.ready,
                   in_valid_ff && rsp_valid_ff && !rsp_chan.ready,
                   "input stalled without downstream stall")
endmodule
